[design/asd_pkg.sv]
// Shared types, constants and register codes for the accelerometer shake detector.
// No dependencies; imported by every module of the block.
package asd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SUM_W       = 2 * SAMPLE_BITS + 2;
    localparam int ROOT_W      = SAMPLE_BITS + 1;
    localparam int ROOT_STEPS  = SUM_W / 2;
    localparam int ITER_W      = $clog2(ROOT_STEPS);
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int TIME_W      = 32;
    localparam int DEV_W       = 16;
    localparam int DIFF_W      = (ROOT_W > DEV_W) ? ROOT_W : DEV_W;
    localparam int CNT_W       = 4;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ONE_G          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEVEL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVITY_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PEAKS_NEEDED   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS    = 3'd6;

    localparam logic [14:0]      RST_ONE_G          = 15'd4096;
    localparam logic [15:0]      RST_PEAK_LEVEL     = 16'd6144;
    localparam logic [15:0]      RST_RELEASE_LEVEL  = 16'd2048;
    localparam logic [15:0]      RST_ACTIVITY_LEVEL = 16'd410;
    localparam logic [15:0]      RST_WINDOW_MS      = 16'd600;
    localparam logic [CNT_W-1:0] RST_PEAKS_NEEDED   = 4'd3;
    localparam logic [15:0]      RST_COOLDOWN_MS    = 16'd1000;

    localparam logic [DEV_W-1:0] DEV_MAX = {DEV_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [14:0]      one_g;
        logic [15:0]      peak_level;
        logic [15:0]      release_level;
        logic [15:0]      activity_level;
        logic [15:0]      window_ms;
        logic [CNT_W-1:0] peaks_needed;
        logic [15:0]      cooldown_ms;
    } t_cfg;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [TIME_W-1:0] time_ms;
    } t_qword;

    typedef struct packed {
        logic              shake_event;
        logic              activity;
        logic              peak_seen;
        logic [CNT_W-1:0]  peak_total;
        logic [DEV_W-1:0]  deviation;
    } t_result;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_SQUARE,
        FS_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_ROOT,
        BS_DEV,
        BS_EVAL
    } t_back_state;

endpackage

[design/accel_shake_detector.sv]
// Top level of the accelerometer shake detector: config registers, front end,
// word queue and back end. Depends on asd_pkg, asd_cfg, asd_front, asd_queue, asd_back.
//
//   channel   handshake                 payload
//   in        i_in_valid / o_in_ready   i_accel_x, i_accel_y, i_accel_z, i_time_ms
//   out       o_out_valid / i_out_ready o_shake_event, o_activity,
//                                       o_peak_seen, o_peak_total, o_deviation
//   cfg       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Front end: per word it takes the sample, squares the three axes on one multiplier,
// sums the squares and pushes. Back end: the 17-step bit-serial square root sets its
// pace, and the back end sets the sustained rate.
// A two-word queue lets the front take new words while the back or the output stalls.
// Synchronous active-low reset; config is always ready, one result per input word.
module accel_shake_detector
    import asd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [15:0]           i_accel_x,
    input  logic [15:0]           i_accel_y,
    input  logic [15:0]           i_accel_z,
    input  logic [TIME_W-1:0]     i_time_ms,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_shake_event,
    output logic                  o_activity,
    output logic                  o_peak_seen,
    output logic [CNT_W-1:0]      o_peak_total,
    output logic [DEV_W-1:0]      o_deviation,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_qword  push_word, head_word;
    t_result result;
    logic    q_push, q_full, q_pop, q_avail;

    asd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    asd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_accel_x  (i_accel_x),
        .i_accel_y  (i_accel_y),
        .i_accel_z  (i_accel_z),
        .i_time_ms  (i_time_ms),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_word   (push_word)
    );

    asd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (push_word),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_word  (head_word)
    );

    asd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_avail   (q_avail),
        .i_q_word    (head_word),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_shake_event = result.shake_event;
    assign o_activity    = result.activity;
    assign o_peak_seen   = result.peak_seen;
    assign o_peak_total  = result.peak_total;
    assign o_deviation   = result.deviation;

endmodule

[design/asd_cfg.sv]
// Configuration register file of the shake detector.
// Depends on asd_pkg for the register codes, reset values and t_cfg.
module asd_cfg
    import asd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_g          <= RST_ONE_G;
            r_cfg.peak_level     <= RST_PEAK_LEVEL;
            r_cfg.release_level  <= RST_RELEASE_LEVEL;
            r_cfg.activity_level <= RST_ACTIVITY_LEVEL;
            r_cfg.window_ms      <= RST_WINDOW_MS;
            r_cfg.peaks_needed   <= RST_PEAKS_NEEDED;
            r_cfg.cooldown_ms    <= RST_COOLDOWN_MS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ONE_G:          r_cfg.one_g          <= i_cfg_data[14:0];
                REG_PEAK_LEVEL:     r_cfg.peak_level     <= i_cfg_data;
                REG_RELEASE_LEVEL:  r_cfg.release_level  <= i_cfg_data;
                REG_ACTIVITY_LEVEL: r_cfg.activity_level <= i_cfg_data;
                REG_WINDOW_MS:      r_cfg.window_ms      <= i_cfg_data;
                REG_PEAKS_NEEDED:   r_cfg.peaks_needed   <= i_cfg_data[CNT_W-1:0];
                REG_COOLDOWN_MS:    r_cfg.cooldown_ms    <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[design/asd_front.sv]
// Front end: takes a sample word, squares the three axes on one shared multiplier
// and pushes the sum of squares with its timestamp into the queue. Uses asd_pkg.
module asd_front
    import asd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [15:0]       i_accel_x,
    input  logic [15:0]       i_accel_y,
    input  logic [15:0]       i_accel_z,
    input  logic [TIME_W-1:0] i_time_ms,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_qword            o_q_word
);

    t_front_state r_state, n_state;

    logic [SAMPLE_BITS-1:0] r_abs_x, r_abs_y, r_abs_z;
    logic [TIME_W-1:0]      r_time;
    logic [1:0]             r_step;
    logic [PROD_W-1:0]      r_prod;
    logic [SUM_W-1:0]       r_sum;

    logic                   accept;
    logic [SAMPLE_BITS-1:0] abs_x, abs_y, abs_z, operand;

    function automatic logic [SAMPLE_BITS-1:0] mag_of(input logic [SAMPLE_BITS-1:0] v);
        // most negative code maps to 2^(SAMPLE_BITS-1), still fits unsigned
        return v[SAMPLE_BITS-1] ? SAMPLE_BITS'(~v + 1'b1) : v;
    endfunction

    assign abs_x = mag_of(i_accel_x[SAMPLE_BITS-1:0]);
    assign abs_y = mag_of(i_accel_y[SAMPLE_BITS-1:0]);
    assign abs_z = mag_of(i_accel_z[SAMPLE_BITS-1:0]);

    always_comb begin
        case (r_step)
            2'd0:    operand = r_abs_x;
            2'd1:    operand = r_abs_y;
            default: operand = r_abs_z;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE:   if (i_in_valid) n_state = FS_SQUARE;
            FS_SQUARE: if (r_step == 2'd3) n_state = FS_PUSH;
            FS_PUSH:   if (!i_q_full) n_state = FS_IDLE;
            default:   n_state = FS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_q_push   = 1'b0;
        case (r_state)
            FS_IDLE: o_in_ready = 1'b1;
            FS_PUSH: o_q_push   = !i_q_full;
            default: ;
        endcase
    end

    assign accept           = i_in_valid && o_in_ready;
    assign o_q_word.sum     = r_sum;
    assign o_q_word.time_ms = r_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_step  <= 2'd0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_step <= 2'd0;
            end else if (r_state == FS_SQUARE) begin
                r_step <= r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_abs_x <= abs_x;
            r_abs_y <= abs_y;
            r_abs_z <= abs_z;
            r_time  <= i_time_ms;
            r_sum   <= '0;
        end else if (r_state == FS_SQUARE) begin
            // product of step s lands in the sum at step s+1
            if (r_step != 2'd3) begin
                r_prod <= operand * operand;
            end
            if (r_step != 2'd0) begin
                r_sum <= r_sum + SUM_W'(r_prod);
            end
        end
    end

endmodule

[design/asd_queue.sv]
// Short FIFO of sum-of-squares words between front and back end.
// Depends on asd_pkg for t_qword and the depth constants.
module asd_queue
    import asd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qword i_word,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_avail,
    output t_qword o_word
);

    t_qword              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_avail = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

[design/asd_back.sv]
// Back end: bit-serial integer square root, deviation from one g, then the
// peak / window / cooldown update and the output register. Uses asd_pkg.
module asd_back
    import asd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_avail,
    input  t_qword  i_q_word,
    output logic    o_q_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    t_back_state r_state, n_state;

    logic [SUM_W-1:0]  r_rem, r_root, r_bit;
    logic [ITER_W-1:0] r_iter;
    logic [TIME_W-1:0] r_time, r_since_shake;
    logic [DEV_W-1:0]  r_dev;

    logic              r_latch;
    logic [TIME_W-1:0] r_first_peak;
    logic [CNT_W-1:0]  r_count;
    logic [TIME_W-1:0] r_last_shake;

    t_result           r_out;
    logic              r_out_valid;

    logic              commit;
    logic [SUM_W-1:0]  trial;
    logic [DIFF_W-1:0] root_ext, g_ext, diff;
    logic [DEV_W-1:0]  dev_sat;

    logic              is_above, is_below, is_active, new_peak, shake;
    logic [CNT_W-1:0]  cnt_a, cnt_b;
    logic [TIME_W-1:0] first_a;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: if (i_q_avail) n_state = BS_ROOT;
            BS_ROOT: if (r_iter == '0) n_state = BS_DEV;
            BS_DEV:  n_state = BS_EVAL;
            BS_EVAL: if (!r_out_valid || i_out_ready) n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_pop = 1'b0;
        commit  = 1'b0;
        case (r_state)
            BS_IDLE: o_q_pop = i_q_avail;
            BS_EVAL: commit  = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    // one root bit per cycle
    assign trial = r_root + r_bit;

    assign root_ext = DIFF_W'(r_root[ROOT_W-1:0]);
    assign g_ext    = DIFF_W'(i_cfg.one_g);
    assign diff     = (root_ext >= g_ext) ? root_ext - g_ext : g_ext - root_ext;
    assign dev_sat  = (diff > DIFF_W'(DEV_MAX)) ? DEV_MAX : diff[DEV_W-1:0];

    // peak, latch, window and cooldown on the registered deviation
    always_comb begin
        is_above  = r_dev > i_cfg.peak_level;
        is_below  = r_dev < i_cfg.release_level;
        is_active = r_dev > i_cfg.activity_level;
        new_peak  = is_above && !r_latch;

        cnt_a   = r_count;
        first_a = r_first_peak;
        if (new_peak) begin
            if (r_count == '0) begin
                first_a = r_time;
            end
            if (r_count != CNT_MAX) begin
                cnt_a = r_count + 1'b1;
            end
        end

        cnt_b = ((r_time - first_a) > TIME_W'(i_cfg.window_ms)) ? '0 : cnt_a;
        shake = (cnt_b >= i_cfg.peaks_needed) &&
                (r_since_shake > TIME_W'(i_cfg.cooldown_ms));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BS_IDLE;
            r_out_valid  <= 1'b0;
            r_latch      <= 1'b0;
            r_first_peak <= '0;
            r_count      <= '0;
            r_last_shake <= '0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_out_valid  <= 1'b1;
                r_first_peak <= first_a;
                r_count      <= shake ? '0 : cnt_b;
                if (shake) begin
                    r_last_shake <= r_time;
                end
                if (is_below) begin
                    r_latch <= 1'b0;
                end else if (is_above) begin
                    r_latch <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                r_rem  <= i_q_word.sum;
                r_root <= '0;
                r_bit  <= {2'b01, {(SUM_W - 2){1'b0}}};
                r_iter <= ITER_W'(ROOT_STEPS - 1);
                r_time <= i_q_word.time_ms;
            end
            BS_ROOT: begin
                if (r_rem >= trial) begin
                    r_rem  <= r_rem - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit  <= r_bit >> 2;
                r_iter <= r_iter - 1'b1;
            end
            BS_DEV: begin
                r_dev         <= dev_sat;
                r_since_shake <= r_time - r_last_shake;
            end
            default: ;
        endcase
        if (commit) begin
            r_out.shake_event <= shake;
            r_out.activity    <= is_active;
            r_out.peak_seen   <= new_peak;
            r_out.peak_total  <= shake ? '0 : cnt_b;
            r_out.deviation   <= r_dev;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

[design/asd_checker.sv]
// Port-level checker for accel_shake_detector, attached by the bind below.
// Depends on asd_pkg for widths.
module asd_checker
    import asd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_shake_event,
    input logic                  o_activity,
    input logic                  o_peak_seen,
    input logic [CNT_W-1:0]      o_peak_total,
    input logic [DEV_W-1:0]      o_deviation
);

    // a stalled result word keeps valid, deviation, peak total and shake event
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_deviation) &&
        $stable(o_peak_total) && $stable(o_shake_event))
        else $error("result word changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a shake always restarts the peak count
    a_shake_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_shake_event |-> o_peak_total == '0)
        else $error("peak count not cleared on shake");

    // a peak or activity needs a nonzero deviation
    a_peak_dev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_peak_seen || o_activity) |-> o_deviation != '0)
        else $error("peak or activity with zero deviation");

endmodule

bind accel_shake_detector asd_checker u_asd_checker (.*);
